FILE: hw/rtl/stack_machine_instruction_step_unit_defines.svh
// Assertion macros used by the port-level checker.
`ifndef STACK_MACHINE_INSTRUCTION_STEP_UNIT_DEFINES_SVH
`define STACK_MACHINE_INSTRUCTION_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, reset gated.
`define SMIS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smis check failed");

// Next-cycle implication, reset gated.
`define SMIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smis check failed");

`endif

FILE: hw/rtl/smis_pkg.sv
// Shared constants, opcodes and types of the instruction step unit.
package smis_pkg;

    localparam int MEM_ADDR_BITS_DEF   = 16;
    localparam int STACK_ADDR_BITS_DEF = 16;
    localparam int NUM_REGS_DEF        = 5;

    localparam int          WORD_W     = 16;
    localparam int          INSN_WORDS = 5;
    localparam logic [15:0] BIT_TOP    = 16'd7;
    localparam logic [15:0] ALL_ONES   = 16'hFFFF;

    // operand types
    localparam logic [15:0] TY_REG   = 16'h0000;
    localparam logic [15:0] TY_MEM   = 16'h0001;
    localparam logic [15:0] TY_IMM   = 16'h0002;
    localparam logic [15:0] TY_PTR   = 16'h0003;
    localparam logic [15:0] TY_CONST = 16'hFFFF;

    // opcodes
    localparam logic [15:0] OP_NOP  = 16'h0000;
    localparam logic [15:0] OP_MOV  = 16'h0001;
    localparam logic [15:0] OP_PTR  = 16'h0002;
    localparam logic [15:0] OP_PUSH = 16'h0003;
    localparam logic [15:0] OP_POP  = 16'h0004;
    localparam logic [15:0] OP_ADD  = 16'h0005;
    localparam logic [15:0] OP_SUB  = 16'h0006;
    localparam logic [15:0] OP_MUL  = 16'h0007;
    localparam logic [15:0] OP_DIV  = 16'h0008;
    localparam logic [15:0] OP_CMP  = 16'h0009;
    localparam logic [15:0] OP_JMP  = 16'h000A;
    localparam logic [15:0] OP_JE   = 16'h000B;
    localparam logic [15:0] OP_JNE  = 16'h000C;
    localparam logic [15:0] OP_JG   = 16'h000D;
    localparam logic [15:0] OP_JL   = 16'h000E;
    localparam logic [15:0] OP_CALL = 16'h000F;
    localparam logic [15:0] OP_RET  = 16'h0010;
    localparam logic [15:0] OP_BTST = 16'h0011;
    localparam logic [15:0] OP_LDB  = 16'h0012;
    localparam logic [15:0] OP_AND  = 16'h0013;
    localparam logic [15:0] OP_OR   = 16'h0014;
    localparam logic [15:0] OP_XOR  = 16'h0015;
    localparam logic [15:0] OP_NOT  = 16'h0016;
    localparam logic [15:0] OP_SHL  = 16'h0017;
    localparam logic [15:0] OP_SHR  = 16'h0018;
    localparam logic [15:0] OP_HALT = 16'hFFFF;

    // flag bit positions
    localparam int FL_BIT = 0;
    localparam int FL_EQ  = 1;
    localparam int FL_LT  = 2;
    localparam int FL_GT  = 3;

    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } t_div_rsp;

endpackage

FILE: hw/rtl/smis_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smis_ram #(
    parameter int WIDTH     = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_BITS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/smis_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module smis_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smis_pkg::t_div_req i_req,
    output smis_pkg::t_div_rsp o_rsp
);
    import smis_pkg::*;

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_den, n_den;
    logic [16:0] rem_sh;
    logic [16:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[15]};
        rem_sub = rem_sh - {1'b0, r_den};
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd16;
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 5'd1;
                if (!rem_sub[16]) begin
                    n_rem = rem_sub[15:0];
                    n_quo = {r_quo[14:0], 1'b1};
                end else begin
                    n_rem = rem_sh[15:0];
                    n_quo = {r_quo[14:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done = r_busy && (r_cnt == 5'd0);
    assign o_rsp.quo  = r_quo;

endmodule

FILE: hw/rtl/stack_machine_instruction_step_unit.sv
// Top level of the 16-bit instruction step unit: sequencer, registers, memories.
//
// Each input word is either a program load (i_func = 0), which writes one word of
// program memory, or an execute step (i_func = 1), which runs one five-word
// instruction at the instruction pointer. Every word yields exactly one result
// word carrying the new instruction pointer, general register zero, the halt
// state and an error bit for unknown opcodes or operand types. A load passes
// through the accept step, then the result step, which posts the result once the
// output register is free. A step passes through the accept step, which issues
// the first read, a fetch step per instruction word through the single read port
// of program memory, steps to read the source and destination operands from that
// same port, an execute and write-back step, and the result step. A divide by a
// nonzero source also waits for the bit-serial divider. Steps while halted go
// from the accept step to the result step, like a load. One word is in flight at
// a time; the output register lets the next word be accepted while the previous
// result still waits. Program memory and the return stack hold no reset values
// and must be written before they are read.
module stack_machine_instruction_step_unit #(
    parameter int MEM_ADDR_BITS   = smis_pkg::MEM_ADDR_BITS_DEF,
    parameter int STACK_ADDR_BITS = smis_pkg::STACK_ADDR_BITS_DEF,
    parameter int NUM_REGS        = smis_pkg::NUM_REGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [15:0] i_load_addr,
    input  logic [15:0] i_load_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_ip,
    output logic [15:0] o_reg_zero,
    output logic        o_halted,
    output logic        o_bad_code
);
    import smis_pkg::*;

    localparam int IDXW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_SRC   = 7'b0000100,
        S_DST   = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic [15:0] r_w [INSN_WORDS];
    logic [15:0] n_w [INSN_WORDS];
    logic [15:0] r_ip, n_ip;
    logic [15:0] r_sp, n_sp;
    logic [15:0] r_gr [NUM_REGS];
    logic [15:0] n_gr [NUM_REGS];
    logic [3:0]  r_flags, n_flags;
    logic        r_run, n_run;
    logic [15:0] r_src, n_src;
    logic        r_sbad, n_sbad;
    logic        r_bad, n_bad;
    logic        r_ovalid, n_ovalid;
    logic [15:0] r_o_ip, n_o_ip;
    logic [15:0] r_o_r0, n_o_r0;
    logic        r_o_halt, n_o_halt;
    logic        r_o_bad, n_o_bad;

    // instruction fields
    logic [15:0] op, dt, da, st, sa;

    // program memory port
    logic                     pm_we;
    logic [15:0]              pm_waddr, pm_raddr;
    logic [15:0]              pm_wdata, pm_rdata;
    // return stack port
    logic                     rs_we;
    logic [15:0]              rs_wdata, rs_rdata;
    logic [15:0]              sp_dec;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // execute-stage values
    logic [15:0] dv;
    logic        dbad;
    logic        d01, d013;
    logic [31:0] prod;
    logic        dw_en;
    logic [15:0] dw_val;
    logic        bt_hit;
    logic [15:0] bt_sh;
    logic        take;

    function automatic logic [15:0] f_rd_reg(input logic [15:0] idx);
        logic [15:0] v;
        v = '0;
        if (idx < 16'(NUM_REGS)) begin
            v = r_gr[idx[IDXW-1:0]];
        end
        return v;
    endfunction

    assign op = r_w[0];
    assign dt = r_w[1];
    assign da = r_w[2];
    assign st = r_w[3];
    assign sa = r_w[4];

    assign sp_dec = r_sp - 16'd1;
    assign o_ready = (r_state == S_IDLE);

    smis_ram #(.WIDTH(WORD_W), .ADDR_BITS(MEM_ADDR_BITS)) u_pm (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr[MEM_ADDR_BITS-1:0]),
        .i_wdata (pm_wdata),
        .i_raddr (pm_raddr[MEM_ADDR_BITS-1:0]),
        .o_rdata (pm_rdata)
    );

    // pop reads at sp-1; the address is steady from acceptance to execute
    smis_ram #(.WIDTH(WORD_W), .ADDR_BITS(STACK_ADDR_BITS)) u_rs (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (r_sp[STACK_ADDR_BITS-1:0]),
        .i_wdata (rs_wdata),
        .i_raddr (sp_dec[STACK_ADDR_BITS-1:0]),
        .o_rdata (rs_rdata)
    );

    smis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // read address per phase
    always_comb begin
        unique case (r_state)
            S_IDLE:  pm_raddr = r_ip;
            S_FETCH: pm_raddr = r_ip + {13'd0, r_cnt} + 16'd1;
            S_SRC:   pm_raddr = (st == TY_PTR) ? f_rd_reg(sa) : sa;
            S_DST:   pm_raddr = (dt == TY_PTR) ? f_rd_reg(da) : da;
            default: pm_raddr = r_ip;
        endcase
    end

    // destination operand, from memory read issued in the DST phase
    always_comb begin
        dbad = 1'b0;
        if (dt == TY_MEM || dt == TY_PTR) begin
            dv = pm_rdata;
        end else if (dt == TY_REG) begin
            dv = f_rd_reg(da);
        end else if (dt == TY_IMM) begin
            dv = da;
        end else if (dt == TY_CONST) begin
            dv = ALL_ONES;
        end else begin
            dv   = '0;
            dbad = 1'b1;
        end
    end

    assign d01    = (dt == TY_REG) || (dt == TY_MEM);
    assign d013   = d01 || (dt == TY_PTR);
    assign prod   = dv * r_src;
    assign bt_sh  = BIT_TOP - r_src;
    assign bt_hit = (r_src <= BIT_TOP) && dv[bt_sh[3:0]];

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_w      = r_w;
        n_ip     = r_ip;
        n_sp     = r_sp;
        n_gr     = r_gr;
        n_flags  = r_flags;
        n_run    = r_run;
        n_src    = r_src;
        n_sbad   = r_sbad;
        n_bad    = r_bad;
        n_ovalid = r_ovalid;
        n_o_ip   = r_o_ip;
        n_o_r0   = r_o_r0;
        n_o_halt = r_o_halt;
        n_o_bad  = r_o_bad;
        pm_we    = 1'b0;
        pm_waddr = i_load_addr;
        pm_wdata = i_load_data;
        rs_we    = 1'b0;
        rs_wdata = dv;
        div_req  = '{start: 1'b0, num: dv, den: r_src};
        dw_en    = 1'b0;
        dw_val   = '0;
        take     = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bad = 1'b0;
                    n_cnt = '0;
                    if (!i_func) begin
                        pm_we   = 1'b1;
                        n_state = S_DONE;
                    end else if (!r_run) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_w[r_cnt] = pm_rdata;
                n_cnt      = r_cnt + 3'd1;
                if (r_cnt == 3'(INSN_WORDS - 1)) begin
                    n_ip    = r_ip + 16'(INSN_WORDS);
                    n_state = S_SRC;
                end
            end
            S_SRC: begin
                n_state = S_DST;
            end
            S_DST: begin
                n_sbad = 1'b0;
                if (st == TY_MEM || st == TY_PTR) begin
                    n_src = pm_rdata;
                end else if (st == TY_REG) begin
                    n_src = f_rd_reg(sa);
                end else if (st == TY_IMM) begin
                    n_src = sa;
                end else if (st == TY_CONST) begin
                    n_src = ALL_ONES;
                end else begin
                    n_src  = '0;
                    n_sbad = 1'b1;
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_bad   = r_sbad;
                n_state = S_DONE;
                unique case (op)
                    OP_NOP: ;
                    OP_MOV: begin
                        dw_en  = d013;
                        dw_val = r_src;
                    end
                    OP_PTR: begin
                        pm_we    = 1'b1;
                        pm_waddr = dv;
                        pm_wdata = r_src;
                        n_bad    = r_sbad | dbad;
                    end
                    OP_PUSH: begin
                        rs_we = 1'b1;
                        n_sp  = r_sp + 16'd1;
                        n_bad = r_sbad | dbad;
                    end
                    OP_POP: begin
                        if (d01) begin
                            dw_en  = 1'b1;
                            dw_val = rs_rdata;
                            n_sp   = sp_dec;
                        end
                    end
                    OP_ADD: begin
                        dw_en  = d013;
                        dw_val = dv + r_src;
                    end
                    OP_SUB: begin
                        dw_en  = d01;
                        dw_val = dv - r_src;
                    end
                    OP_MUL: begin
                        dw_en  = d01;
                        dw_val = prod[15:0];
                    end
                    OP_DIV: begin
                        if (d01) begin
                            if (r_src == 16'd0) begin
                                dw_en  = 1'b1;
                                dw_val = ALL_ONES;
                            end else begin
                                div_req.start = 1'b1;
                                n_state       = S_DIV;
                            end
                        end
                    end
                    OP_CMP: begin
                        n_flags = {dv > r_src, dv < r_src, dv == r_src, r_flags[FL_BIT]};
                        n_bad   = r_sbad | dbad;
                    end
                    OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JL: begin
                        priority if (op == OP_JMP) take = 1'b1;
                        else if (op == OP_JE)      take = r_flags[FL_EQ];
                        else if (op == OP_JNE)     take = !r_flags[FL_EQ];
                        else if (op == OP_JG)      take = r_flags[FL_GT];
                        else                       take = r_flags[FL_LT];
                        if (take) begin
                            n_ip  = (dv << 2) + dv;
                            n_bad = r_sbad | dbad;
                        end
                    end
                    OP_CALL: begin
                        rs_we    = 1'b1;
                        rs_wdata = r_ip;
                        n_sp     = r_sp + 16'd1;
                        n_ip     = (dv << 2) + dv;
                        n_bad    = r_sbad | dbad;
                    end
                    OP_RET: begin
                        n_ip = rs_rdata;
                        n_sp = sp_dec;
                    end
                    OP_BTST: begin
                        if (d01) begin
                            n_flags = {r_flags[FL_GT], r_flags[FL_LT], bt_hit, bt_hit};
                        end
                    end
                    OP_LDB: begin
                        dw_en  = d01;
                        dw_val = {15'd0, r_flags[FL_BIT]};
                    end
                    OP_AND: begin
                        dw_en  = (dt == TY_REG);
                        dw_val = dv & r_src;
                    end
                    OP_OR: begin
                        dw_en  = (dt == TY_REG);
                        dw_val = dv | r_src;
                    end
                    OP_XOR: begin
                        dw_en  = (dt == TY_REG);
                        dw_val = dv ^ r_src;
                    end
                    OP_NOT: begin
                        dw_en  = d01;
                        dw_val = ~dv;
                    end
                    OP_SHL: begin
                        dw_en  = d01;
                        dw_val = (r_src >= 16'd16) ? 16'd0 : (dv << r_src[3:0]);
                    end
                    OP_SHR: begin
                        dw_en  = d01;
                        dw_val = (r_src >= 16'd16) ? 16'd0 : (dv >> r_src[3:0]);
                    end
                    OP_HALT: begin
                        n_run = 1'b0;
                    end
                    default: begin
                        n_bad = 1'b1;
                    end
                endcase
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    dw_en   = 1'b1;
                    dw_val  = div_rsp.quo;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_o_ip   = r_ip;
                    n_o_r0   = r_gr[0];
                    n_o_halt = !r_run;
                    n_o_bad  = r_bad;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // destination write-back: register, memory word or memory via register
        if (dw_en) begin
            if (dt == TY_REG) begin
                if (da < 16'(NUM_REGS)) begin
                    n_gr[da[IDXW-1:0]] = dw_val;
                end
            end else begin
                pm_we    = 1'b1;
                pm_waddr = (dt == TY_MEM) ? da : f_rd_reg(da);
                pm_wdata = dw_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ip     <= '0;
            r_sp     <= '0;
            r_gr     <= '{default: '0};
            r_flags  <= '0;
            r_run    <= 1'b1;
            r_bad    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ip     <= n_ip;
            r_sp     <= n_sp;
            r_gr     <= n_gr;
            r_flags  <= n_flags;
            r_run    <= n_run;
            r_bad    <= n_bad;
            r_ovalid <= n_ovalid;
        end
        r_w      <= n_w;
        r_src    <= n_src;
        r_sbad   <= n_sbad;
        r_o_ip   <= n_o_ip;
        r_o_r0   <= n_o_r0;
        r_o_halt <= n_o_halt;
        r_o_bad  <= n_o_bad;
    end

    assign o_valid    = r_ovalid;
    assign o_next_ip  = r_o_ip;
    assign o_reg_zero = r_o_r0;
    assign o_halted   = r_o_halt;
    assign o_bad_code = r_o_bad;

endmodule

FILE: hw/rtl/smis_chk.sv
// Port-level checker for the instruction step unit, bound to the top level.
`include "stack_machine_instruction_step_unit_defines.svh"

module smis_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_func,
    input logic [15:0] i_load_addr,
    input logic [15:0] i_load_data,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_next_ip,
    input logic [15:0] o_reg_zero,
    input logic        o_halted,
    input logic        o_bad_code
);

    // stalled result holds
    `SMIS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_next_ip) && $stable(o_reg_zero))

    // one word in flight: busy right after acceptance
    `SMIS_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)

    // halt is sticky until reset
    `SMIS_ASSERT_NEXT(a_halt_sticky, o_valid && o_halted, !o_valid || o_halted)

    // ready comes back only after a busy stretch, never right on an accept
    `SMIS_ASSERT_IMPL(a_ready_quiet, o_ready && !$past(o_ready) && $past(i_rst_n), !$past(i_valid && o_ready))

endmodule

bind stack_machine_instruction_step_unit smis_chk u_smis_chk (.*);
